FILE: hw/rtl/zrbpd_pkg.sv
// Shared types and constants for the zero-run bit-packed pixel decoder.
package zrbpd_pkg;

	localparam int unsigned SRC_W   = 8;
	localparam int unsigned PIX_W   = 8;
	localparam int unsigned LEN_W   = 32;
	localparam int unsigned CNT_W   = 15;
	localparam int unsigned BPP_W   = 4;
	localparam int unsigned DIM_W   = 16;
	localparam int unsigned OUT_W   = 40;
	localparam int unsigned CFG_A_W = 2;

	localparam logic [BPP_W-1:0] BPP_RESET    = 4'd4;
	localparam logic [BPP_W-1:0] BPP_MAX      = 4'd8;
	localparam logic [BPP_W-1:0] BPP_MIN      = 4'd1;
	localparam logic [4:0]       CODE_BITS    = 5'd16;

	typedef enum logic [CFG_A_W-1:0] {
		CFG_BPP    = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2
	} cfg_reg_t;

	// run handed from the bit decoder to the clipping stage
	typedef struct packed {
		logic             valid;
		logic             eoi;
		logic [PIX_W-1:0] value;
		logic [CNT_W-1:0] count;
	} run_req_t;

endpackage

FILE: hw/rtl/zrbpd_bitdec.sv
// Bit-serial symbol/run-count decoder, one bit per unstalled shift.
module zrbpd_bitdec (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [zrbpd_pkg::SRC_W-1:0]           s_axis_tdata,
	input  logic                                  s_axis_tlast,
	input  logic [zrbpd_pkg::BPP_W-1:0]           bpp,
	input  logic                                  slot_free,
	output zrbpd_pkg::run_req_t                   req
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SHIFT = 4'b0010,
		ST_TAIL  = 4'b0100,
		ST_FINAL = 4'b1000
	} state_t;

	state_t                            state_q;
	logic [zrbpd_pkg::SRC_W-1:0]       sh_q;
	logic [2:0]                        nb_q;
	logic                              last_q;
	logic                              cnt_mode_q;
	logic [2:0]                        k_q;
	logic [zrbpd_pkg::PIX_W-1:0]       sym_q;
	logic [3:0]                        got_q;
	logic [zrbpd_pkg::CNT_W-1:0]       acc_q;

	logic [zrbpd_pkg::BPP_W-1:0]       bpp_eff;
	logic [3:0]                        cw;
	logic                              b;
	logic [zrbpd_pkg::PIX_W-1:0]       sym_full;
	logic [zrbpd_pkg::CNT_W-1:0]       acc_full;
	logic                              sym_done;
	logic                              cnt_done;
	logic                              advance;

	always_comb begin
		if (bpp == '0) begin
			bpp_eff = zrbpd_pkg::BPP_MIN;
		end else if (bpp > zrbpd_pkg::BPP_MAX) begin
			bpp_eff = zrbpd_pkg::BPP_MAX;
		end else begin
			bpp_eff = bpp;
		end
	end

	assign cw       = 4'(zrbpd_pkg::CODE_BITS - {1'b0, bpp_eff});
	assign b        = sh_q[0];
	assign sym_full = sym_q | ({7'b0, b} << k_q);
	assign acc_full = acc_q | ({14'b0, b} << got_q);
	assign sym_done = (({1'b0, k_q} + 4'd1) == bpp_eff);
	assign cnt_done = ((got_q + 4'd1) == cw);

	always_comb begin
		req = '0;
		case (state_q)
			ST_SHIFT: begin
				if (cnt_mode_q) begin
					req.valid = cnt_done;
					req.count = acc_full;
				end else begin
					req.valid = sym_done && (sym_full != '0);
					req.value = sym_full;
					req.count = 15'd1;
				end
			end
			ST_TAIL: begin
				if (cnt_mode_q) begin
					req.valid = 1'b1;
					req.count = acc_q;
				end else begin
					req.valid = (sym_q != '0);
					req.value = sym_q;
					req.count = 15'd1;
				end
			end
			ST_FINAL: begin
				req.valid = 1'b1;
				req.eoi   = 1'b1;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	assign advance       = !req.valid || slot_free;
	assign s_axis_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sh_q       <= '0;
			nb_q       <= '0;
			last_q     <= 1'b0;
			cnt_mode_q <= 1'b0;
			k_q        <= '0;
			sym_q      <= '0;
			got_q      <= '0;
			acc_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						sh_q    <= s_axis_tdata;
						last_q  <= s_axis_tlast;
						nb_q    <= '0;
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (advance) begin
						sh_q <= sh_q >> 1;
						nb_q <= nb_q + 3'd1;
						if (cnt_mode_q) begin
							if (cnt_done) begin
								cnt_mode_q <= 1'b0;
								got_q      <= '0;
								acc_q      <= '0;
							end else begin
								got_q <= got_q + 4'd1;
								acc_q <= acc_full;
							end
						end else begin
							if (sym_done) begin
								k_q        <= '0;
								sym_q      <= '0;
								cnt_mode_q <= (sym_full == '0);
								got_q      <= '0;
								acc_q      <= '0;
							end else begin
								k_q   <= k_q + 3'd1;
								sym_q <= sym_full;
							end
						end
						if (nb_q == 3'd7) begin
							state_q <= last_q ? ST_TAIL : ST_IDLE;
						end
					end
				end
				ST_TAIL: begin
					if (advance) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (advance) begin
						cnt_mode_q <= 1'b0;
						k_q        <= '0;
						sym_q      <= '0;
						got_q      <= '0;
						acc_q      <= '0;
						last_q     <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/zrbpd_clip.sv
// Budget clipping and output register for decoded runs.
module zrbpd_clip (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [zrbpd_pkg::LEN_W-1:0]           budget,
	input  zrbpd_pkg::run_req_t                   req,
	output logic                                  slot_free,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [zrbpd_pkg::OUT_W-1:0]           m_axis_tdata,
	output logic                                  m_axis_tlast
);

	logic [zrbpd_pkg::LEN_W-1:0]   emitted_q;
	logic                          out_valid_q;
	logic [zrbpd_pkg::PIX_W-1:0]   out_value_q;
	logic [zrbpd_pkg::LEN_W-1:0]   out_len_q;
	logic                          out_eoi_q;

	logic [zrbpd_pkg::LEN_W:0]     diff;
	logic [zrbpd_pkg::LEN_W-1:0]   rem;
	logic [zrbpd_pkg::LEN_W-1:0]   count32;
	logic [zrbpd_pkg::LEN_W-1:0]   sum;
	logic                          clipped;
	logic [zrbpd_pkg::LEN_W-1:0]   len;
	logic [zrbpd_pkg::LEN_W-1:0]   emitted_next;
	logic                          load;
	logic                          take;

	assign diff    = {1'b0, budget} - {1'b0, emitted_q};
	assign rem     = diff[zrbpd_pkg::LEN_W] ? '0 : diff[zrbpd_pkg::LEN_W-1:0];
	assign count32 = {{(zrbpd_pkg::LEN_W-zrbpd_pkg::CNT_W){1'b0}}, req.count};
	assign sum     = emitted_q + count32;
	assign clipped = (rem[zrbpd_pkg::LEN_W-1:zrbpd_pkg::CNT_W] == '0)
		&& (req.count >= rem[zrbpd_pkg::CNT_W-1:0]);

	always_comb begin
		if (req.eoi) begin
			len          = rem;
			emitted_next = '0;
		end else if (clipped) begin
			len          = rem;
			emitted_next = diff[zrbpd_pkg::LEN_W] ? emitted_q : budget;
		end else begin
			len          = count32;
			emitted_next = sum;
		end
	end

	assign slot_free = !out_valid_q || m_axis_tready;
	assign take      = req.valid && slot_free;
	assign load      = take && (req.eoi || (len != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emitted_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				emitted_q <= emitted_next;
			end
			if (slot_free) begin
				out_valid_q <= load;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_value_q <= req.value;
			out_len_q   <= len;
			out_eoi_q   <= req.eoi;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_len_q, out_value_q};
	assign m_axis_tlast  = out_eoi_q;

endmodule

FILE: hw/rtl/zero_run_bitpacked_pixel_decoder_unit.sv
// Top level of the zero-run bit-packed pixel decoder.
// Each compressed byte is taken in while the decoder is idle and then shifted out, one stream
// bit per step, through a shift register that feeds the symbol and count decoder; no new byte
// is taken until all its bits are used. The byte marked last adds two steps, one for a
// trailing partial symbol or cut-off count and one for the end-of-image word. A bit step
// that yields a run waits while the output register still holds an untaken word. Runs are
// clipped to width*height pixels; that product is formed when a size register is written.
module zero_run_bitpacked_pixel_decoder_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [zrbpd_pkg::SRC_W-1:0]           s_axis_tdata,  // [7:0] src_byte
	input  logic                                  s_axis_tlast,  // last_byte
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [zrbpd_pkg::OUT_W-1:0]           m_axis_tdata,  // [7:0] pixel_value, [39:8] run_length
	output logic                                  m_axis_tlast,  // end_of_image
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [zrbpd_pkg::CFG_A_W-1:0]         cfg_index,
	input  logic [zrbpd_pkg::DIM_W-1:0]           cfg_data
);

	logic [zrbpd_pkg::BPP_W-1:0]   bpp_q;
	logic [zrbpd_pkg::DIM_W-1:0]   width_q;
	logic [zrbpd_pkg::DIM_W-1:0]   height_q;
	logic [zrbpd_pkg::LEN_W-1:0]   budget_q;
	logic                          slot_free;
	zrbpd_pkg::run_req_t           req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q    <= zrbpd_pkg::BPP_RESET;
			width_q  <= '0;
			height_q <= '0;
			budget_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				zrbpd_pkg::CFG_BPP: begin
					bpp_q <= cfg_data[zrbpd_pkg::BPP_W-1:0];
				end
				zrbpd_pkg::CFG_WIDTH: begin
					width_q  <= cfg_data;
					budget_q <= {{(zrbpd_pkg::LEN_W-zrbpd_pkg::DIM_W){1'b0}}, cfg_data}
						* {{(zrbpd_pkg::LEN_W-zrbpd_pkg::DIM_W){1'b0}}, height_q};
				end
				zrbpd_pkg::CFG_HEIGHT: begin
					height_q <= cfg_data;
					budget_q <= {{(zrbpd_pkg::LEN_W-zrbpd_pkg::DIM_W){1'b0}}, width_q}
						* {{(zrbpd_pkg::LEN_W-zrbpd_pkg::DIM_W){1'b0}}, cfg_data};
				end
				default: begin
					bpp_q <= bpp_q;
				end
			endcase
		end
	end

	zrbpd_bitdec u_bitdec (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.bpp           (bpp_q),
		.slot_free     (slot_free),
		.req           (req)
	);

	zrbpd_clip u_clip (
		.clk           (clk),
		.arst_n        (arst_n),
		.budget        (budget_q),
		.req           (req),
		.slot_free     (slot_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

FILE: hw/rtl/zrbpd_chk.sv
// Port-level checks on the decoder output stream, bound to the top level.
module zrbpd_chk (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	input  logic [zrbpd_pkg::OUT_W-1:0]           m_axis_tdata,
	input  logic                                  m_axis_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[39:8] != 32'd0)
		else $error("empty run before end of image");

	a_pixel_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[7:0] != 8'd0) |->
		(m_axis_tdata[39:8] == 32'd1) && !m_axis_tlast)
		else $error("nonzero pixel run not of length one");

	a_eoi_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[7:0] == 8'd0)
		else $error("end of image word carries a pixel value");

endmodule

bind zero_run_bitpacked_pixel_decoder_unit zrbpd_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the zero-run bit-packed pixel decoder unit.
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned SRC_W   = zrbpd_pkg::SRC_W;
	localparam int unsigned PIX_W   = zrbpd_pkg::PIX_W;
	localparam int unsigned LEN_W   = zrbpd_pkg::LEN_W;
	localparam int unsigned CNT_W   = zrbpd_pkg::CNT_W;
	localparam int unsigned BPP_W   = zrbpd_pkg::BPP_W;
	localparam int unsigned DIM_W   = zrbpd_pkg::DIM_W;
	localparam int unsigned OUT_W   = zrbpd_pkg::OUT_W;
	localparam int unsigned CFG_A_W = zrbpd_pkg::CFG_A_W;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic [LEN_W-1:0] length;
		logic             eoi;
	} pixel_run_t;

	typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		zrbpd_pkg::cfg_reg_t   reg_idx;
		logic [DIM_W-1:0]      data;
		logic                  last;
		logic                  known;
		pixel_run_t            want;
	} plan_row_t;

	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned LONG_HOLD     = 500;
	localparam int unsigned BYTES_TOTAL   = 330;
	localparam int unsigned CALM_FROM     = 290;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [SRC_W-1:0]   s_axis_tdata;
	logic               s_axis_tlast;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [OUT_W-1:0]   m_axis_tdata;
	logic               m_axis_tlast;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CFG_A_W-1:0] cfg_index;
	logic [DIM_W-1:0]   cfg_data;

	// decoder state as the block should hold it
	logic [BPP_W-1:0] bpp_reg;
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	logic [15:0]      stream_bits;
	int unsigned      stream_held;
	bit               in_zero_count;
	logic [CNT_W-1:0] zero_count;
	int unsigned      zero_count_got;
	logic [LEN_W-1:0] px_sent;

	pixel_run_t runs_due[$];
	pixel_run_t seen_run;
	pixel_run_t want_run;
	plan_row_t  plan [34];

	int unsigned mismatches;
	int unsigned runs_checked;
	int unsigned bytes_sent;
	int unsigned images_sent;
	int unsigned cfg_writes;
	bit          calm;
	bit          rx_hold_req;
	bit          hold_done;
	bit          pause_done;

	zero_run_bitpacked_pixel_decoder_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic plan_row_t cfg_row(zrbpd_pkg::cfg_reg_t r, logic [DIM_W-1:0] d);
		plan_row_t p;
		p = '0;
		p.kind = ROW_CFG;
		p.reg_idx = r;
		p.data = d;
		return p;
	endfunction

	function automatic plan_row_t byte_row(logic [SRC_W-1:0] d, logic l);
		plan_row_t p;
		p = '0;
		p.kind = ROW_BYTE;
		p.data = DIM_W'(d);
		p.last = l;
		return p;
	endfunction

	function automatic plan_row_t known_row(logic [SRC_W-1:0] d, logic l, logic [PIX_W-1:0] v,
			logic [LEN_W-1:0] n, logic e);
		plan_row_t p;
		p = byte_row(d, l);
		p.known = 1'b1;
		p.want = pixel_run_t'{v, n, e};
		return p;
	endfunction

	function automatic logic [LEN_W-1:0] budget_left();
		logic [LEN_W-1:0] total;
		total = LEN_W'(width_reg) * LEN_W'(height_reg);
		return (px_sent >= total) ? '0 : total - px_sent;
	endfunction

	function automatic void add_run(logic [PIX_W-1:0] v, logic [LEN_W-1:0] cnt);
		logic [LEN_W-1:0] left;
		logic [LEN_W-1:0] n;
		left = budget_left();
		n = (cnt < left) ? cnt : left;
		if (n == 0) return;
		px_sent += n;
		runs_due.push_back(pixel_run_t'{v, n, 1'b0});
	endfunction

	// work out the runs one compressed byte releases
	function automatic void decode_byte(logic [SRC_W-1:0] b, logic lst);
		int unsigned w;
		int unsigned cw;
		int unsigned need;
		int unsigned take;
		logic [PIX_W-1:0] sym;
		w = bpp_reg;
		if (w == 0) w = 1;
		else if (w > zrbpd_pkg::BPP_MAX) w = zrbpd_pkg::BPP_MAX;
		cw = 32'(zrbpd_pkg::CODE_BITS) - w;
		stream_bits = stream_bits | (16'(b) << stream_held);
		stream_held += 8;
		while (1'b1) begin
			if (in_zero_count) begin
				need = cw - zero_count_got;
				take = (need < stream_held) ? need : stream_held;
				if (take == 0) break;
				zero_count = zero_count |
					CNT_W'((32'(stream_bits) & ((32'd1 << take) - 1)) << zero_count_got);
				zero_count_got += take;
				stream_bits = stream_bits >> take;
				stream_held -= take;
				if (zero_count_got >= cw) begin
					in_zero_count = 1'b0;
					add_run('0, LEN_W'(zero_count));
					zero_count = '0;
					zero_count_got = 0;
				end
			end else begin
				if (stream_held < w) break;
				sym = PIX_W'(32'(stream_bits) & ((32'd1 << w) - 1));
				stream_bits = stream_bits >> w;
				stream_held -= w;
				if (sym != 0) begin
					add_run(sym, 1);
				end else if (stream_held > 0 || !lst) begin
					in_zero_count = 1'b1;
					zero_count = '0;
					zero_count_got = 0;
				end
			end
		end
		if (lst) begin
			if (in_zero_count) begin
				add_run('0, LEN_W'(zero_count));
			end else if (stream_held > 0) begin
				sym = PIX_W'(32'(stream_bits) & ((32'd1 << stream_held) - 1));
				if (sym != 0) add_run(sym, 1);
			end
			runs_due.push_back(pixel_run_t'{8'd0, budget_left(), 1'b1});
			stream_bits = '0;
			stream_held = 0;
			in_zero_count = 1'b0;
			zero_count = '0;
			zero_count_got = 0;
			px_sent = '0;
		end
	endfunction

	task automatic idle_until_drained(int unsigned settle);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (runs_due.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(zrbpd_pkg::cfg_reg_t r, logic [DIM_W-1:0] d);
		idle_until_drained(SETTLE_CYCLES);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (r)
			zrbpd_pkg::CFG_BPP: begin
				bpp_reg = d[BPP_W-1:0];
			end
			zrbpd_pkg::CFG_WIDTH: begin
				width_reg = d;
			end
			zrbpd_pkg::CFG_HEIGHT: begin
				height_reg = d;
			end
			default: begin
			end
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_word(logic [SRC_W-1:0] d, logic l, logic known, pixel_run_t want);
		int unsigned mark;
		if (!calm && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tlast <= l;
		do @(posedge clk); while (!s_axis_tready);
		mark = runs_due.size();
		decode_byte(d, l);
		if (known) begin
			while (runs_due.size() > mark) void'(runs_due.pop_back());
			runs_due.push_back(want);
		end
		bytes_sent++;
		if (l) images_sent++;
		if (bytes_sent >= CALM_FROM) calm = 1'b1;
	endtask

	function automatic void note_mismatch(string what, pixel_run_t want, pixel_run_t seen);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected value %0d length %0d eoi %0d, got value %0d length %0d eoi %0d",
				$realtime, what, want.value, want.length, want.eoi,
				seen.value, seen.length, seen.eoi);
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_run = pixel_run_t'{m_axis_tdata[PIX_W-1:0], m_axis_tdata[OUT_W-1:PIX_W],
				m_axis_tlast};
			if (runs_due.size() == 0) begin
				note_mismatch("unexpected word", '0, seen_run);
			end else begin
				want_run = runs_due.pop_front();
				runs_checked++;
				if (want_run != seen_run) note_mismatch("wrong word", want_run, seen_run);
			end
		end
	end

	// output side: random stalls, one long hold on request
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				rx_hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(0, 17)) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("zero_run_bitpacked_pixel_decoder_unit regression: fail");
		$finish;
	end

	initial begin
		int unsigned img_len;
		logic [SRC_W-1:0] b;
		logic [BPP_W-1:0] bpp_pick;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = zrbpd_pkg::CFG_BPP;
		cfg_data = '0;
		bpp_reg = zrbpd_pkg::BPP_RESET;
		width_reg = '0;
		height_reg = '0;
		stream_bits = '0;
		stream_held = 0;
		in_zero_count = 1'b0;
		zero_count = '0;
		zero_count_got = 0;
		px_sent = '0;
		mismatches = 0;
		runs_checked = 0;
		bytes_sent = 0;
		images_sent = 0;
		cfg_writes = 0;
		calm = 1'b0;
		rx_hold_req = 1'b0;
		hold_done = 1'b0;
		pause_done = 1'b0;

		plan = '{
			known_row(8'h00, 1'b1, 8'd0, 32'd0, 1'b1),
			cfg_row(zrbpd_pkg::CFG_WIDTH, 16'd4),
			cfg_row(zrbpd_pkg::CFG_HEIGHT, 16'd3),
			byte_row(8'h21, 1'b0),
			byte_row(8'h30, 1'b0),
			byte_row(8'h00, 1'b0),
			byte_row(8'hFF, 1'b1),
			cfg_row(zrbpd_pkg::CFG_BPP, 16'd1),
			byte_row(8'hFF, 1'b0),
			byte_row(8'hFF, 1'b0),
			byte_row(8'h01, 1'b1),
			cfg_row(zrbpd_pkg::CFG_BPP, 16'd8),
			cfg_row(zrbpd_pkg::CFG_WIDTH, 16'hFFFF),
			cfg_row(zrbpd_pkg::CFG_HEIGHT, 16'hFFFF),
			byte_row(8'hAB, 1'b0),
			byte_row(8'h00, 1'b0),
			byte_row(8'hFF, 1'b0),
			byte_row(8'h00, 1'b0),
			byte_row(8'h80, 1'b1),
			cfg_row(zrbpd_pkg::CFG_WIDTH, 16'd2),
			cfg_row(zrbpd_pkg::CFG_HEIGHT, 16'd3),
			known_row(8'h00, 1'b1, 8'd0, 32'd6, 1'b1),
			cfg_row(zrbpd_pkg::CFG_BPP, 16'd4),
			byte_row(8'h50, 1'b1),
			cfg_row(zrbpd_pkg::CFG_BPP, 16'd3),
			byte_row(8'hFF, 1'b1),
			byte_row(8'h3F, 1'b1),
			cfg_row(zrbpd_pkg::CFG_BPP, 16'hFFF0),
			byte_row(8'hFF, 1'b0),
			cfg_row(zrbpd_pkg::CFG_WIDTH, 16'd1),
			known_row(8'h03, 1'b1, 8'd0, 32'd0, 1'b1),
			cfg_row(zrbpd_pkg::CFG_BPP, 16'h000F),
			byte_row(8'h00, 1'b0),
			byte_row(8'h07, 1'b1)
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_reg(plan[i].reg_idx, plan[i].data);
			else
				send_word(plan[i].data[SRC_W-1:0], plan[i].last, plan[i].known, plan[i].want);
		end

		while (bytes_sent < BYTES_TOTAL) begin
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 3))
					0: bpp_pick = zrbpd_pkg::BPP_MIN;
					1: bpp_pick = zrbpd_pkg::BPP_MAX;
					default: bpp_pick = 4'($urandom_range(0, 15));
				endcase
				write_reg(zrbpd_pkg::CFG_BPP, {12'($urandom_range(0, 4095)), bpp_pick});
			end
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 9))
					0: write_reg(zrbpd_pkg::CFG_WIDTH, 16'd0);
					1: write_reg(zrbpd_pkg::CFG_WIDTH, 16'hFFFF);
					default: write_reg(zrbpd_pkg::CFG_WIDTH, 16'($urandom_range(1, 24)));
				endcase
			end
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 9))
					0: write_reg(zrbpd_pkg::CFG_HEIGHT, 16'd0);
					1: write_reg(zrbpd_pkg::CFG_HEIGHT, 16'hFFFF);
					default: write_reg(zrbpd_pkg::CFG_HEIGHT, 16'($urandom_range(1, 24)));
				endcase
			end
			img_len = $urandom_range(1, 10);
			// fill the block while the output side is held off
			if (!hold_done && bytes_sent >= 120) begin
				hold_done = 1'b1;
				rx_hold_req = 1'b1;
				img_len = 16;
			end
			for (int k = 0; k < img_len; k++) begin
				if ($urandom_range(0, 3) == 0)
					b = 8'($urandom_range(0, 255)) & 8'($urandom_range(0, 255));
				else
					b = 8'($urandom_range(0, 255));
				send_word(b, k == img_len - 1, 1'b0, '0);
				if (k != img_len - 1 && img_len != 16) begin
					if (!pause_done && bytes_sent >= 200) begin
						pause_done = 1'b1;
						idle_until_drained(0);
					end else if ($urandom_range(0, 11) == 0) begin
						if ($urandom_range(0, 1) == 0)
							write_reg(zrbpd_pkg::CFG_WIDTH, 16'($urandom_range(0, 12)));
						else
							write_reg(zrbpd_pkg::CFG_HEIGHT, 16'($urandom_range(0, 12)));
					end
				end
			end
		end

		idle_until_drained(SETTLE_CYCLES);
		$display("Decoded %0d bytes in %0d images over %0d register writes;",
			bytes_sent, images_sent, cfg_writes);
		$display("%0d runs compared, %0d mismatches.", runs_checked, mismatches);
		if (mismatches == 0) begin
			$display("zero_run_bitpacked_pixel_decoder_unit regression: pass");
		end else begin
			$display("zero_run_bitpacked_pixel_decoder_unit regression: fail");
		end
		$finish;
	end

endmodule
